@@ src/hfc_pkg.sv @@
// Shared types, constants and a helper function of the Haar feature classifier.
`default_nettype none

package hfc_pkg;

    // Default integral window edge length
    localparam int WINDOW_SIZE_DEF = 24;

    // Field widths
    localparam int COORD_W = 5;
    localparam int TYPE_W  = 3;
    localparam int VALUE_W = 18;
    localparam int SUM_W   = 20;
    localparam int CFG_W   = 20;
    localparam int CFG_AW  = 3;

    // Accumulator holds the signed sum of up to sixteen unsigned 18-bit terms
    localparam int ACC_W = 24;

    // Stream word widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_AW-1:0] REG_LEFT      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_TOP       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_RIGHT     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BOTTOM    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TYPE      = 3'd4;
    localparam logic [CFG_AW-1:0] REG_POLARITY  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd6;

    // Feature selectors
    localparam logic [TYPE_W-1:0] FT_HORIZ_TWO   = 3'd0;
    localparam logic [TYPE_W-1:0] FT_VERT_TWO    = 3'd1;
    localparam logic [TYPE_W-1:0] FT_HORIZ_THREE = 3'd2;
    localparam logic [TYPE_W-1:0] FT_VERT_THREE  = 3'd3;
    localparam logic [TYPE_W-1:0] FT_CHECKER     = 3'd4;

    // Item kinds on the input stream
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;     // write the accepted entry into the store
        logic       prep;     // latch split points, clear accumulator
        logic       issue;    // read one corner entry
        logic [3:0] step;     // corner lookup number
        logic       capture;  // move the finished sum into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic step_last;  // current step is the last corner of the feature
        logic no_terms;   // unknown feature type, sum is zero
    } t_dp_sts;

    // Signed divide by three, truncating toward zero, for a 7-bit signed input (-64 to 63)
    function automatic logic signed [6:0] div3_trunc(input logic signed [6:0] v);
        logic [6:0]  mag;
        logic [15:0] prod;
        logic [6:0]  q;
        mag  = v[6] ? 7'(-v) : 7'(v);
        prod = 16'(mag) * 16'd171;
        q    = prod[15:9];
        return v[6] ? $signed(7'(-q)) : $signed(q);
    endfunction

endpackage

`default_nettype wire

@@ src/haar_feature_weak_classifier.sv @@
// Top level of the Haar-like feature weak classifier.
//
// Input stream (s_axis): each word is either a load of one integral image
// entry (tuser = 0) or an evaluate request (tuser = 1). A load writes the
// entry in the cycle it is accepted, so loads stream at one word per cycle
// while no evaluation runs; loads with row or column outside the window are dropped.
// An evaluate word computes the configured feature over the integral store,
// one corner entry per cycle through the single read port of the store:
// 8 corners for two-part features, 12 for three-part, 16 for checkerboard.
// An evaluation goes through the prepare, corner read, drain and finish states;
// an unknown feature type goes from prepare straight to finish. Input ready
// returns together with the result landing in the output register.
// Output stream (m_axis): one word per evaluate, saturated feature sum and
// the face decision. The output register holds a finished word while the
// receiver stalls; a following evaluation runs and then waits for the slot.
// Configuration writes (i_cfg_*) take effect at once; the user must make them while idle,
// the block does not enforce this. Reset is synchronous: configuration registers
// return to the full-window two-part setup, the store content is undefined until loaded.
`default_nettype none

module haar_feature_weak_classifier #(
    parameter int WINDOW_SIZE = hfc_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [hfc_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [hfc_pkg::CFG_W-1:0]         i_cfg_wdata,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [hfc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // row[4:0], column[9:5], value[27:10]
    input  wire logic [0:0]                        s_axis_tuser,  // kind[0]
    // output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [hfc_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // feature_sum[19:0]
    output logic [0:0]                             m_axis_tuser   // decision[0]
);

    hfc_pkg::t_dp_cmd                   cmd;
    hfc_pkg::t_dp_sts                   sts;
    logic signed [hfc_pkg::SUM_W-1:0]   feature_sum;
    logic                               decision;

    hfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_kind     (s_axis_tuser[0]),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    hfc_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_row         (s_axis_tdata[4:0]),
        .i_column      (s_axis_tdata[9:5]),
        .i_value       (s_axis_tdata[27:10]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_feature_sum (feature_sum),
        .o_decision    (decision)
    );

    assign m_axis_tdata = {{(hfc_pkg::M_TDATA_W - hfc_pkg::SUM_W){1'b0}}, feature_sum};
    assign m_axis_tuser = decision;

endmodule

`default_nettype wire

@@ src/hfc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hfc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 576
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/hfc_datapath.sv @@
// Datapath: config registers, integral store, corner addressing, accumulator, output register.
`default_nettype none

module hfc_datapath #(
    parameter int WINDOW_SIZE = hfc_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [hfc_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [hfc_pkg::CFG_W-1:0]      i_cfg_wdata,
    // load entry fields
    input  wire logic [hfc_pkg::COORD_W-1:0]    i_row,
    input  wire logic [hfc_pkg::COORD_W-1:0]    i_column,
    input  wire logic [hfc_pkg::VALUE_W-1:0]    i_value,
    // control
    input  wire hfc_pkg::t_dp_cmd               i_cmd,
    output hfc_pkg::t_dp_sts                    o_sts,
    // result
    output logic signed [hfc_pkg::SUM_W-1:0]    o_feature_sum,
    output logic                                o_decision
);

    localparam int DEPTH = WINDOW_SIZE * WINDOW_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(WINDOW_SIZE + 1);
    localparam int ACC_W = hfc_pkg::ACC_W;
    localparam int SUM_W = hfc_pkg::SUM_W;
    localparam int CDW   = hfc_pkg::COORD_W;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (SUM_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(1 << (SUM_W - 1));

    // Configuration registers
    logic [CDW-1:0]                   r_left, r_top, r_right, r_bottom;
    logic [hfc_pkg::TYPE_W-1:0]       r_type;
    logic                             r_polarity;
    logic signed [SUM_W-1:0]          r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_top       <= '0;
            r_right     <= CDW'(WINDOW_SIZE);
            r_bottom    <= CDW'(WINDOW_SIZE);
            r_type      <= hfc_pkg::FT_HORIZ_TWO;
            r_polarity  <= 1'b0;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                hfc_pkg::REG_LEFT:      r_left      <= i_cfg_wdata[CDW-1:0];
                hfc_pkg::REG_TOP:       r_top       <= i_cfg_wdata[CDW-1:0];
                hfc_pkg::REG_RIGHT:     r_right     <= i_cfg_wdata[CDW-1:0];
                hfc_pkg::REG_BOTTOM:    r_bottom    <= i_cfg_wdata[CDW-1:0];
                hfc_pkg::REG_TYPE:      r_type      <= i_cfg_wdata[hfc_pkg::TYPE_W-1:0];
                hfc_pkg::REG_POLARITY:  r_polarity  <= i_cfg_wdata[0];
                hfc_pkg::REG_THRESHOLD: r_threshold <= $signed(i_cfg_wdata[SUM_W-1:0]);
                default: ;
            endcase
        end
    end

    // Split points: halves and truncating thirds of the rectangle
    logic signed [6:0] dx, dy, dx1, dy1, dx2, dy2;
    logic [CDW-1:0]    n_xm, n_ym, n_x1, n_x2, n_y1, n_y2;
    logic [CDW:0]      sum_x, sum_y;

    always_comb begin
        sum_x = {1'b0, r_left} + {1'b0, r_right};
        sum_y = {1'b0, r_top} + {1'b0, r_bottom};
        n_xm  = sum_x[CDW:1];
        n_ym  = sum_y[CDW:1];
        dx    = $signed({2'b00, r_right}) - $signed({2'b00, r_left});
        dy    = $signed({2'b00, r_bottom}) - $signed({2'b00, r_top});
        dx1   = hfc_pkg::div3_trunc(dx);
        dx2   = hfc_pkg::div3_trunc(dx <<< 1);
        dy1   = hfc_pkg::div3_trunc(dy);
        dy2   = hfc_pkg::div3_trunc(dy <<< 1);
        n_x1  = CDW'($signed({2'b00, r_left}) + dx1);
        n_x2  = CDW'($signed({2'b00, r_left}) + dx2);
        n_y1  = CDW'($signed({2'b00, r_top}) + dy1);
        n_y2  = CDW'($signed({2'b00, r_top}) + dy2);
    end

    logic [CDW-1:0] r_xm, r_ym, r_x1, r_x2, r_y1, r_y2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_xm <= n_xm;
            r_ym <= n_ym;
            r_x1 <= n_x1;
            r_x2 <= n_x2;
            r_y1 <= n_y1;
            r_y2 <= n_y2;
        end
    end

    // Step count per feature type
    logic [3:0] last_step;

    always_comb begin
        last_step      = 4'd0;
        o_sts.no_terms = 1'b0;
        case (r_type)
            hfc_pkg::FT_HORIZ_TWO,
            hfc_pkg::FT_VERT_TWO:    last_step = 4'd7;
            hfc_pkg::FT_HORIZ_THREE,
            hfc_pkg::FT_VERT_THREE:  last_step = 4'd11;
            hfc_pkg::FT_CHECKER:     last_step = 4'd15;
            default:                 o_sts.no_terms = 1'b1;
        endcase
        o_sts.step_last = (i_cmd.step == last_step);
    end

    // Area bounds for the current step: columns [ax0, ax1), rows [ay0, ay1)
    logic [CDW-1:0] ax0, ay0, ax1, ay1;
    logic           area_neg;

    always_comb begin
        ax0 = r_left;
        ay0 = r_top;
        ax1 = r_right;
        ay1 = r_bottom;
        area_neg = 1'b0;
        case (r_type)
            hfc_pkg::FT_HORIZ_TWO: begin
                if (i_cmd.step[2]) begin
                    ax0 = r_xm; area_neg = 1'b1;
                end else begin
                    ax1 = r_xm;
                end
            end
            hfc_pkg::FT_VERT_TWO: begin
                if (i_cmd.step[2]) begin
                    ay0 = r_ym; area_neg = 1'b1;
                end else begin
                    ay1 = r_ym;
                end
            end
            hfc_pkg::FT_HORIZ_THREE: begin
                case (i_cmd.step[3:2])
                    2'd0:    ax1 = r_x1;
                    2'd1:    begin ax0 = r_x1; ax1 = r_x2; area_neg = 1'b1; end
                    default: ax0 = r_x2;
                endcase
            end
            hfc_pkg::FT_VERT_THREE: begin
                case (i_cmd.step[3:2])
                    2'd0:    ay1 = r_y1;
                    2'd1:    begin ay0 = r_y1; ay1 = r_y2; area_neg = 1'b1; end
                    default: ay0 = r_y2;
                endcase
            end
            hfc_pkg::FT_CHECKER: begin
                case (i_cmd.step[3:2])
                    2'd0:    begin ax1 = r_xm; ay1 = r_ym; end
                    2'd1:    begin ax0 = r_xm; ay0 = r_ym; end
                    2'd2:    begin ax0 = r_xm; ay1 = r_ym; area_neg = 1'b1; end
                    default: begin ax1 = r_xm; ay0 = r_ym; area_neg = 1'b1; end
                endcase
            end
            default: ;
        endcase
    end

    // Corner of the area: far corner and near corner add, mixed corners subtract
    logic [CDW-1:0] cr, cc;
    logic           corner_neg;

    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    begin cr = ay1; cc = ax1; corner_neg = 1'b0; end
            2'd1:    begin cr = ay0; cc = ax1; corner_neg = 1'b1; end
            2'd2:    begin cr = ay1; cc = ax0; corner_neg = 1'b1; end
            default: begin cr = ay0; cc = ax0; corner_neg = 1'b0; end
        endcase
    end

    // Clamp to the window and form the store address; zero edge reads as zero
    logic [CW-1:0] cr_c, cc_c;
    logic          corner_zero;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;

    always_comb begin
        cr_c        = (32'(cr) > WINDOW_SIZE) ? CW'(WINDOW_SIZE) : CW'(cr);
        cc_c        = (32'(cc) > WINDOW_SIZE) ? CW'(WINDOW_SIZE) : CW'(cc);
        corner_zero = (cr == '0) || (cc == '0);
        rd_addr     = AW'(32'(CW'(cr_c - 1'b1)) * WINDOW_SIZE) + AW'(CW'(cc_c - 1'b1));
        wr_addr     = AW'(32'(i_row) * WINDOW_SIZE + 32'(i_column));
        wr_en       = i_cmd.load && (32'(i_row) < WINDOW_SIZE)
                      && (32'(i_column) < WINDOW_SIZE);
    end

    logic [hfc_pkg::VALUE_W-1:0] rd_data;

    hfc_ram #(
        .WIDTH (hfc_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_value),
        .i_re    (i_cmd.issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Term control is registered together with the read, in step with the read data
    logic r_term_vld, r_term_neg, r_term_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_vld <= 1'b0;
        end else begin
            r_term_vld <= i_cmd.issue;
        end
        r_term_neg  <= area_neg ^ corner_neg;
        r_term_zero <= corner_zero;
    end

    // Accumulator
    logic signed [ACC_W-1:0] r_acc, n_acc, term;

    always_comb begin
        term  = $signed(ACC_W'(rd_data));
        n_acc = r_acc;
        if (i_cmd.prep) begin
            n_acc = '0;
        end else if (r_term_vld && !r_term_zero) begin
            n_acc = r_term_neg ? r_acc - term : r_acc + term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Threshold test on the full sum, then saturate for output
    logic signed [ACC_W-1:0] thr_ext;
    logic                    n_dec;
    logic signed [SUM_W-1:0] n_sat;

    always_comb begin
        thr_ext = ACC_W'(r_threshold);
        n_dec   = r_polarity ? (r_acc <= thr_ext) : (r_acc >= thr_ext);
        if (r_acc > SAT_MAX) begin
            n_sat = SAT_MAX[SUM_W-1:0];
        end else if (r_acc < SAT_MIN) begin
            n_sat = SAT_MIN[SUM_W-1:0];
        end else begin
            n_sat = r_acc[SUM_W-1:0];
        end
    end

    logic signed [SUM_W-1:0] r_sum_out;
    logic                    r_dec_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sum_out <= n_sat;
            r_dec_out <= n_dec;
        end
    end

    assign o_feature_sum = r_sum_out;
    assign o_decision    = r_dec_out;

endmodule

`default_nettype wire

@@ src/hfc_ctrl.sv @@
// Controller: input handshake, evaluation sequencer and output valid flag.
`default_nettype none

module hfc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic              i_kind,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output hfc_pkg::t_dp_cmd       o_cmd,
    input  wire hfc_pkg::t_dp_sts  i_sts
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PREP   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    // No word is taken while reset is held
    assign o_s_tready = i_rst_n && (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_cmd         = '0;
        o_cmd.step    = r_step;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == hfc_pkg::KIND_EVAL) begin
                        n_state = ST_PREP;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = '0;
                n_state    = i_sts.no_terms ? ST_FINISH : ST_READ;
            end
            ST_READ: begin
                o_cmd.issue = 1'b1;
                if (i_sts.step_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output slot: filled on capture, emptied when the word is taken
    always_comb begin
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    // Never overwrite a result that is still waiting
    a_capture_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten while output stalled");

    // An accepted evaluate word starts the sequencer
    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == hfc_pkg::KIND_EVAL) |=> (r_state == ST_PREP))
        else $error("evaluate word did not start the sequence");

    // Drain only follows the last corner read
    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> $past(r_state == ST_READ && i_sts.step_last))
        else $error("drain entered before the last corner read");

    // Loads write only from idle, never during a sequence
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (accept && !o_cmd.issue && !o_cmd.capture))
        else $error("store write outside an accepted load");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the Haar feature weak classifier: stream driver, monitor, predictor.
module tb_top;
    import hfc_pkg::*;

    localparam int WIN = WINDOW_SIZE_DEF;
    localparam logic [CFG_AW-1:0] REG_UNUSED     = 3'd7;
    localparam logic [TYPE_W-1:0] FT_UNKNOWN_LO  = 3'd5;
    localparam logic [TYPE_W-1:0] FT_UNKNOWN_HI  = 3'd7;
    localparam longint SUM_HI = 524287;
    localparam longint SUM_LO = -524288;
    localparam int VALUE_MAX    = 262143;
    localparam int DRAIN_CYCLES = 30;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_WORDS  = 68;

    // one input word and one classifier result
    typedef struct packed {
        logic        kind;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [17:0] value;
    } t_haar_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    face;
    } t_verdict;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr    = '0;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // row[4:0], column[9:5], value[27:10]
    logic [0:0]            s_axis_tuser  = '0;  // kind[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // feature_sum[19:0]
    logic [0:0]            m_axis_tuser;        // decision[0]

    // mirror of the block state
    logic [VALUE_W-1:0]    integral_img [0:WIN*WIN-1];
    int                    win_left      = 0;
    int                    win_top       = 0;
    int                    win_right     = WIN;
    int                    win_bottom    = WIN;
    logic [TYPE_W-1:0]     win_type      = FT_HORIZ_TWO;
    logic                  win_polarity  = 1'b0;
    longint                win_threshold = 0;

    t_haar_word            word_queue[$];
    t_verdict              face_verdicts[$];
    t_haar_word            next_word;
    t_verdict              want;
    int                    errors    = 0;
    int                    src_gap   = 0;
    int                    sink_gap  = 0;
    bit                    steady    = 1'b0;
    bit                    word_taken = 1'b0;

    haar_feature_weak_classifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    // corner lookup; the zero edge reads as zero, far coordinates clamp to the window
    function automatic longint corner_at(int r, int c);
        if (r <= 0 || c <= 0) return 0;
        if (r > WIN) r = WIN;
        if (c > WIN) c = WIN;
        return longint'(integral_img[(r - 1) * WIN + (c - 1)]);
    endfunction

    // columns [xa, xb), rows [ya, yb)
    function automatic longint area_sum(int xa, int ya, int xb, int yb);
        return corner_at(yb, xb) - corner_at(ya, xb) - corner_at(yb, xa) + corner_at(ya, xa);
    endfunction

    function automatic longint feature_value();
        int xa, ya, xb, yb, xm, ym, x1, x2, y1, y2;
        xa = win_left;
        ya = win_top;
        xb = win_right;
        yb = win_bottom;
        xm = (xa + xb) / 2;
        ym = (ya + yb) / 2;
        x1 = xa + (xb - xa) / 3;
        x2 = xa + (xb - xa) * 2 / 3;
        y1 = ya + (yb - ya) / 3;
        y2 = ya + (yb - ya) * 2 / 3;
        case (win_type)
            FT_HORIZ_TWO:   return area_sum(xa, ya, xm, yb) - area_sum(xm, ya, xb, yb);
            FT_VERT_TWO:    return area_sum(xa, ya, xb, ym) - area_sum(xa, ym, xb, yb);
            FT_HORIZ_THREE: return area_sum(xa, ya, x1, yb) - area_sum(x1, ya, x2, yb)
                                 + area_sum(x2, ya, xb, yb);
            FT_VERT_THREE:  return area_sum(xa, ya, xb, y1) - area_sum(xa, y1, xb, y2)
                                 + area_sum(xa, y2, xb, yb);
            FT_CHECKER:     return area_sum(xa, ya, xm, ym) + area_sum(xm, ym, xb, yb)
                                 - area_sum(xm, ya, xb, ym) - area_sum(xa, ym, xm, yb);
            default:        return 0;
        endcase
    endfunction

    function automatic longint clamp_sum(longint v);
        if (v > SUM_HI) return SUM_HI;
        if (v < SUM_LO) return SUM_LO;
        return v;
    endfunction

    // decision is taken on the full sum, the reported sum saturates
    function automatic t_verdict classify_window();
        t_verdict vd;
        longint   full;
        full    = feature_value();
        vd.face = win_polarity ? (full <= win_threshold) : (full >= win_threshold);
        vd.sum  = SUM_W'(clamp_sum(full));
        return vd;
    endfunction

    // ---------------- driver and sink ----------------

    // input side: next word after a handshake, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (src_gap > 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (word_queue.size() > 0) begin
                next_word     = word_queue.pop_front();
                s_axis_tdata  <= {4'b0, next_word.value, next_word.col, next_word.row};
                s_axis_tuser  <= next_word.kind;
                s_axis_tvalid <= 1'b1;
                if (!steady && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 8);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: back-pressure in random bursts
    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap      <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 11) == 0) begin
            sink_gap      <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        word_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (word_taken) begin
            if (s_axis_tuser[0] == KIND_LOAD) begin
                if (s_axis_tdata[4:0] < WIN && s_axis_tdata[9:5] < WIN)
                    integral_img[s_axis_tdata[4:0] * WIN + s_axis_tdata[9:5]] =
                        s_axis_tdata[27:10];
            end else begin
                face_verdicts.push_back(classify_window());
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (face_verdicts.size() == 0) begin
                $display("%t: unexpected word: sum %0d decision %0d", $time,
                         $signed(m_axis_tdata[SUM_W-1:0]), m_axis_tuser[0]);
                errors++;
            end else begin
                want = face_verdicts.pop_front();
                if (m_axis_tdata[SUM_W-1:0] !== want.sum) begin
                    $display("%t: feature_sum expected %0d, got %0d", $time,
                             want.sum, $signed(m_axis_tdata[SUM_W-1:0]));
                    errors++;
                end
                if (m_axis_tuser[0] !== want.face) begin
                    $display("%t: decision expected %0d, got %0d", $time,
                             want.face, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic push_load(input int r, input int c, input int v);
        t_haar_word w;
        w.kind  = KIND_LOAD;
        w.row   = r[4:0];
        w.col   = c[4:0];
        w.value = v[17:0];
        word_queue.push_back(w);
    endtask

    // unused fields of an evaluate word carry random bits
    task automatic push_eval();
        t_haar_word w;
        w       = t_haar_word'($urandom);
        w.kind  = KIND_EVAL;
        word_queue.push_back(w);
    endtask

    // register writes go out back to back with the enable held high
    task automatic set_reg(input logic [CFG_AW-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[CFG_W-1:0];
        case (idx)
            REG_LEFT:      win_left      = val & 31;
            REG_TOP:       win_top       = val & 31;
            REG_RIGHT:     win_right     = val & 31;
            REG_BOTTOM:    win_bottom    = val & 31;
            REG_TYPE:      win_type      = val[TYPE_W-1:0];
            REG_POLARITY:  win_polarity  = val[0];
            REG_THRESHOLD: win_threshold = longint'($signed(val[CFG_W-1:0]));
            default: ;
        endcase
    endtask

    task automatic finish_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_rect(input int l, input int t, input int r, input int b);
        set_reg(REG_LEFT, l);
        set_reg(REG_TOP, t);
        set_reg(REG_RIGHT, r);
        set_reg(REG_BOTTOM, b);
    endtask

    // wait for the stream to drain and the last result to land
    task automatic settle();
        while (word_queue.size() != 0 || s_axis_tvalid || face_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // integral image of random 8-bit pixels, loaded row by row
    task automatic fill_image();
        int sums [0:WIN-1][0:WIN-1];
        int acc;
        for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN; c++) begin
                acc = $urandom_range(0, 255);
                if (r > 0) acc += sums[r-1][c];
                if (c > 0) acc += sums[r][c-1];
                if (r > 0 && c > 0) acc -= sums[r-1][c-1];
                sums[r][c] = acc;
                push_load(r, c, acc);
            end
        end
    endtask

    task automatic random_setup();
        int l, t, r, b, pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            l = $urandom_range(0, WIN - 1);
            r = $urandom_range(l + 1, WIN);
            t = $urandom_range(0, WIN - 1);
            b = $urandom_range(t + 1, WIN);
        end else if (pick < 17) begin
            r = $urandom_range(0, WIN - 1);
            l = $urandom_range(r, 31);
            b = $urandom_range(0, 31);
            t = $urandom_range(0, 31);
        end else begin
            l = $urandom_range(0, 31);
            r = $urandom_range(0, 31);
            t = $urandom_range(0, 31);
            b = $urandom_range(0, 31);
        end
        set_rect(l, t, r, b);
        if ($urandom_range(0, 19) < 17)
            set_reg(REG_TYPE, $urandom_range(FT_HORIZ_TWO, FT_CHECKER));
        else
            set_reg(REG_TYPE, $urandom_range(FT_UNKNOWN_LO, FT_UNKNOWN_HI));
        set_reg(REG_POLARITY, $urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            set_reg(REG_THRESHOLD, $urandom);
        else if (pick < 8)
            set_reg(REG_THRESHOLD, $urandom_range(0, 131071) - 65536);
        else
            set_reg(REG_THRESHOLD, int'(clamp_sum(feature_value())));
        if ($urandom_range(0, 4) == 0)
            set_reg(REG_UNUSED, $urandom);
        finish_writes();
    endtask

    // mostly loads and evaluations, a few loads outside the window
    task automatic random_words(input int n);
        int pick, v;
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                push_eval();
            end else if (pick < 19) begin
                case ($urandom_range(0, 9))
                    0:       v = 0;
                    1:       v = VALUE_MAX;
                    2, 3:    v = $urandom_range(0, 4095);
                    default: v = $urandom_range(0, VALUE_MAX);
                endcase
                push_load($urandom_range(0, WIN - 1), $urandom_range(0, WIN - 1), v);
            end else if ($urandom_range(0, 1)) begin
                push_load($urandom_range(WIN, 31), $urandom_range(0, 31), $urandom);
            end else begin
                push_load($urandom_range(0, 31), $urandom_range(WIN, 31), $urandom);
            end
        end
    endtask

    // ---------------- test sequence ----------------

    initial begin
        fill_image();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settle();

        // reset setup: full window, two-part horizontal
        push_eval();
        settle();

        // every feature type on one rectangle
        set_rect(3, 2, 21, 19);
        set_reg(REG_THRESHOLD, 1000);
        set_reg(REG_TYPE, FT_HORIZ_TWO);
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_TYPE, FT_VERT_TWO);
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_TYPE, FT_HORIZ_THREE);
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_TYPE, FT_VERT_THREE);
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_TYPE, FT_CHECKER);
        finish_writes();
        push_eval();
        settle();

        // unknown selectors give a zero sum
        set_reg(REG_TYPE, FT_UNKNOWN_LO);
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_TYPE, FT_UNKNOWN_HI);
        finish_writes();
        push_eval();
        settle();

        // inverted rectangle
        set_rect(20, 18, 4, 5);
        set_reg(REG_TYPE, FT_CHECKER);
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_TYPE, FT_HORIZ_THREE);
        finish_writes();
        push_eval();
        settle();

        // edges past the window clamp
        set_rect(0, 0, 31, 31);
        set_reg(REG_TYPE, FT_VERT_THREE);
        finish_writes();
        push_eval();
        settle();

        // empty parts, corners on the zero edge
        set_rect(7, 0, 7, WIN);
        set_reg(REG_TYPE, FT_HORIZ_TWO);
        finish_writes();
        push_eval();
        settle();
        set_rect(23, 23, WIN, WIN);
        set_reg(REG_TYPE, FT_CHECKER);
        finish_writes();
        push_eval();
        settle();

        // threshold equal to the sum, both polarities, then one above
        set_rect(1, 1, 23, 22);
        set_reg(REG_TYPE, FT_VERT_TWO);
        set_reg(REG_POLARITY, 0);
        set_reg(REG_THRESHOLD, int'(clamp_sum(feature_value())));
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_POLARITY, 1);
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_POLARITY, 0);
        set_reg(REG_THRESHOLD, int'(clamp_sum(feature_value() + 1)));
        finish_writes();
        push_eval();
        settle();

        // threshold extremes; an index past the last register changes nothing
        set_reg(REG_THRESHOLD, int'(SUM_LO));
        set_reg(REG_UNUSED, 20'hFFFFF);
        finish_writes();
        push_eval();
        settle();
        set_reg(REG_POLARITY, 1);
        set_reg(REG_THRESHOLD, int'(SUM_HI));
        finish_writes();
        push_eval();
        settle();

        // loads outside the window are dropped
        push_load(31, 0, VALUE_MAX);
        push_load(0, 31, VALUE_MAX);
        push_load(WIN, WIN, VALUE_MAX);

        // positive overflow: decision on the full sum says no face
        push_load(11, 11, VALUE_MAX);
        push_load(23, 23, VALUE_MAX);
        push_load(11, 23, 0);
        push_load(23, 11, 0);
        settle();
        set_rect(0, 0, WIN, WIN);
        set_reg(REG_TYPE, FT_CHECKER);
        finish_writes();
        push_eval();
        settle();

        // negative overflow against the lowest threshold
        set_reg(REG_POLARITY, 0);
        set_reg(REG_THRESHOLD, int'(SUM_LO));
        finish_writes();
        push_load(11, 11, 0);
        push_load(23, 23, 0);
        push_load(11, 23, VALUE_MAX);
        push_load(23, 11, VALUE_MAX);
        push_eval();
        settle();

        // random phases, the last ones without idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p >= RAND_PHASES - 3)
                steady = 1'b1;
            random_setup();
            random_words(PHASE_WORDS);
            settle();
        end

        if (errors == 0)
            $display("haar_feature_weak_classifier: match");
        else
            $display("haar_feature_weak_classifier: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("haar_feature_weak_classifier: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
src/hfc_pkg.sv
src/hfc_ram.sv
src/hfc_datapath.sv
src/hfc_ctrl.sv
src/haar_feature_weak_classifier.sv
tb/tb_top.sv
